>>> hw/rtl/path_parent_segment_resolver_macros.svh
// Assertion helpers for the path resolver.
`ifndef PATH_PARENT_SEGMENT_RESOLVER_MACROS_SVH
`define PATH_PARENT_SEGMENT_RESOLVER_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define PSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("path resolver check failed");

// Check that cons holds in the cycle after ante.
`define PSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("path resolver check failed");

`endif

>>> hw/rtl/psr_pkg.sv
package psr_pkg;

  localparam int MAX_LEN = 64;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int CNT_W   = $clog2(MAX_LEN + 1);
  localparam int UNIT_W  = 16;

  localparam logic [UNIT_W-1:0] UNIT_BACKSLASH = 16'h005C;
  localparam logic [UNIT_W-1:0] UNIT_SLASH     = 16'h002F;
  localparam logic [UNIT_W-1:0] UNIT_DOT       = 16'h002E;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              last_unit;
  } item_t;

  typedef struct packed {
    logic [UNIT_W-1:0] out_unit;
    logic              out_last;
    logic              path_empty;
    logic              overflow_flag;
    logic              underflow_flag;
  } result_t;

  // Per-result tags that travel beside the buffer read data.
  typedef struct packed {
    logic last;
    logic empty;
    logic ovf;
    logic unf;
  } tag_t;

endpackage

>>> hw/rtl/psr_ram.sv
module psr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Hold read data until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/path_parent_segment_resolver.sv
// Path resolver: takes one UTF-16 code unit of a path per cycle while
// item_stall is low, turns backslashes into slashes and, while
// resolve_parents is 1, removes every segment that is exactly ".." and is
// closed by a separator, together with the segment before it. The path is
// built in a 64-entry buffer; a unit that finds it full is dropped and sets
// overflow_flag, and a ".." with nothing to remove (or that would remove the
// root slash) is dropped and sets underflow_flag. Results appear only after
// the unit marked last_unit: the buffer is then emitted one result per cycle
// while result_stall is low, out_last on the final one, and an empty path
// yields a single result with path_empty set. After a last unit the request
// side is stalled while the n stored units are read out through the single
// buffer read port, and for longer while result_stall keeps the result
// pipeline full. A two-entry result pipeline (buffer read register and
// output register) lets the next path start while the tail of the previous
// one still waits on result_stall. resolve_parents resets to 1 and may be
// rewritten between units; each unit uses the value in force when taken.
`include "path_parent_segment_resolver_macros.svh"

module path_parent_segment_resolver (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write,
  input  logic              cfg_data,
  input  logic              item_valid,
  output logic              item_stall,
  input  psr_pkg::item_t    item,
  output logic              result_valid,
  input  logic              result_stall,
  output psr_pkg::result_t  result
);

  // Path state
  logic                       resolve_parents;
  logic [psr_pkg::CNT_W-1:0]  write_cursor, write_cursor_next;
  logic [psr_pkg::CNT_W-1:0]  stack_count, stack_count_next;
  logic [1:0]                 dot_count, dot_count_next;
  logic                       non_dot, non_dot_next;
  logic                       ovf, ovf_next;
  logic                       unf, unf_next;
  // Cached top two separator positions; the stack RAM holds all entries.
  logic [psr_pkg::ADDR_W-1:0] top, top_next;
  logic [psr_pkg::ADDR_W-1:0] second, second_next;
  logic                       second_pend, second_pend_next;

  // Drain state
  logic [psr_pkg::CNT_W-1:0]  rd_idx, rd_idx_next;
  logic [psr_pkg::CNT_W-1:0]  drain_len, drain_len_next;
  psr_pkg::tag_t              drain_tag, drain_tag_next;
  psr_pkg::tag_t              issue_tag;
  logic                       s1_valid;
  psr_pkg::tag_t              s1_tag;

  // Memory ports
  logic                       buf_we;
  logic [psr_pkg::ADDR_W-1:0] buf_waddr;
  logic [psr_pkg::UNIT_W-1:0] buf_wdata;
  logic                       buf_re;
  logic [psr_pkg::UNIT_W-1:0] buf_rdata;
  logic                       sep_we;
  logic                       sep_re;
  logic [psr_pkg::ADDR_W-1:0] sep_raddr;
  logic [psr_pkg::ADDR_W-1:0] sep_rdata;

  // Per-request decode
  logic                       accept;
  logic                       draining;
  logic                       is_sep;
  logic                       is_parent;
  logic                       pop;
  logic                       has_room;
  logic [psr_pkg::CNT_W-1:0]  seg_start;
  logic [psr_pkg::ADDR_W-1:0] second_eff;
  logic                       issue;
  logic                       s1_move;

  assign draining   = (rd_idx != drain_len);
  assign item_stall = draining;
  assign accept     = item_valid && !item_stall;

  assign is_sep = (item.code_unit == psr_pkg::UNIT_BACKSLASH) ||
                  (item.code_unit == psr_pkg::UNIT_SLASH);
  assign has_room = (write_cursor < psr_pkg::CNT_W'(psr_pkg::MAX_LEN));
  assign seg_start = (stack_count != '0) ?
                     ({1'b0, top} + psr_pkg::CNT_W'(1)) : '0;
  assign is_parent = resolve_parents && (dot_count == 2'd2) && !non_dot &&
                     (write_cursor == seg_start + psr_pkg::CNT_W'(2));
  assign pop = accept && is_sep && is_parent;

  // Use the refill data in the cycle it lands.
  assign second_eff = second_pend ? sep_rdata : second;

  // Buffer write: the unit itself, or a slash for a kept separator.
  assign buf_we    = accept && has_room && !(is_sep && is_parent);
  assign buf_waddr = write_cursor[psr_pkg::ADDR_W-1:0];
  assign buf_wdata = is_sep ? psr_pkg::UNIT_SLASH : item.code_unit;

  // Stack push on a kept separator; refill the second entry after a pop.
  assign sep_we    = accept && is_sep && !is_parent && has_room;
  assign sep_re    = pop && (stack_count > psr_pkg::CNT_W'(2));
  assign sep_raddr = psr_pkg::ADDR_W'(stack_count - psr_pkg::CNT_W'(3));

  always_comb begin
    write_cursor_next = write_cursor;
    stack_count_next  = stack_count;
    dot_count_next    = dot_count;
    non_dot_next      = non_dot;
    ovf_next          = ovf;
    unf_next          = unf;
    top_next          = top;
    second_next       = second_pend ? sep_rdata : second;
    second_pend_next  = 1'b0;
    drain_len_next    = drain_len;
    drain_tag_next    = drain_tag;

    if (accept) begin
      if (is_sep) begin
        dot_count_next = '0;
        non_dot_next   = 1'b0;
        if (is_parent) begin
          if (stack_count == '0) begin
            write_cursor_next = '0;
            unf_next          = 1'b1;
          end else if (stack_count == psr_pkg::CNT_W'(1)) begin
            if (top == '0) begin
              // keep the root slash
              write_cursor_next = psr_pkg::CNT_W'(1);
              unf_next          = 1'b1;
            end else begin
              write_cursor_next = '0;
              stack_count_next  = '0;
            end
          end else begin
            write_cursor_next = {1'b0, second_eff} + psr_pkg::CNT_W'(1);
            stack_count_next  = stack_count - psr_pkg::CNT_W'(1);
            top_next          = second_eff;
            second_pend_next  = sep_re;
          end
        end else if (has_room) begin
          top_next          = write_cursor[psr_pkg::ADDR_W-1:0];
          second_next       = top;
          stack_count_next  = stack_count + psr_pkg::CNT_W'(1);
          write_cursor_next = write_cursor + psr_pkg::CNT_W'(1);
        end else begin
          ovf_next = 1'b1;
        end
      end else begin
        if (item.code_unit == psr_pkg::UNIT_DOT) begin
          if (dot_count != 2'd3) begin
            dot_count_next = dot_count + 2'd1;
          end
        end else begin
          non_dot_next = 1'b1;
        end
        if (has_room) begin
          write_cursor_next = write_cursor + psr_pkg::CNT_W'(1);
        end else begin
          ovf_next = 1'b1;
        end
      end

      if (item.last_unit) begin
        // Hand the finished path to the drain and clear the path state.
        drain_len_next      = (write_cursor_next == '0) ?
                              psr_pkg::CNT_W'(1) : write_cursor_next;
        drain_tag_next.last  = 1'b0;
        drain_tag_next.empty = (write_cursor_next == '0);
        drain_tag_next.ovf   = ovf_next;
        drain_tag_next.unf   = unf_next;
        write_cursor_next    = '0;
        stack_count_next     = '0;
        dot_count_next       = '0;
        non_dot_next         = 1'b0;
        ovf_next             = 1'b0;
        unf_next             = 1'b0;
        second_pend_next     = 1'b0;
      end
    end
  end

  // Drain: advance a read when the read register is free or moving on.
  assign s1_move = s1_valid && (!result_valid || !result_stall);
  assign issue   = draining && (!s1_valid || s1_move);
  assign buf_re  = issue;

  // Tag for the read being issued; mark the final unit of the path.
  always_comb begin
    issue_tag      = drain_tag;
    issue_tag.last = (rd_idx + psr_pkg::CNT_W'(1) == drain_len);
  end

  always_comb begin
    rd_idx_next = rd_idx;
    if (accept && item.last_unit) begin
      rd_idx_next = '0;
    end else if (issue) begin
      rd_idx_next = rd_idx + psr_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resolve_parents <= 1'b1;
    end else if (cfg_write) begin
      resolve_parents <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_cursor <= '0;
      stack_count  <= '0;
      dot_count    <= '0;
      non_dot      <= 1'b0;
      ovf          <= 1'b0;
      unf          <= 1'b0;
      second_pend  <= 1'b0;
      rd_idx       <= '0;
      drain_len    <= '0;
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      write_cursor <= write_cursor_next;
      stack_count  <= stack_count_next;
      dot_count    <= dot_count_next;
      non_dot      <= non_dot_next;
      ovf          <= ovf_next;
      unf          <= unf_next;
      second_pend  <= second_pend_next;
      rd_idx       <= rd_idx_next;
      drain_len    <= drain_len_next;
      if (issue) begin
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    top       <= top_next;
    second    <= second_next;
    drain_tag <= drain_tag_next;
    if (issue) begin
      s1_tag <= issue_tag;
    end
    if (s1_move) begin
      result.out_unit       <= s1_tag.empty ? '0 : buf_rdata;
      result.out_last       <= s1_tag.last;
      result.path_empty     <= s1_tag.empty;
      result.overflow_flag  <= s1_tag.ovf;
      result.underflow_flag <= s1_tag.unf;
    end
  end

  psr_ram #(
    .WIDTH(psr_pkg::UNIT_W),
    .DEPTH(psr_pkg::MAX_LEN)
  ) u_out_buffer (
    .clk  (clk),
    .we   (buf_we),
    .waddr(buf_waddr),
    .wdata(buf_wdata),
    .re   (buf_re),
    .raddr(rd_idx[psr_pkg::ADDR_W-1:0]),
    .rdata(buf_rdata)
  );

  psr_ram #(
    .WIDTH(psr_pkg::ADDR_W),
    .DEPTH(psr_pkg::MAX_LEN)
  ) u_sep_stack (
    .clk  (clk),
    .we   (sep_we),
    .waddr(stack_count[psr_pkg::ADDR_W-1:0]),
    .wdata(write_cursor[psr_pkg::ADDR_W-1:0]),
    .re   (sep_re),
    .raddr(sep_raddr),
    .rdata(sep_rdata)
  );

  // Every stacked separator sits below the cursor.
  `PSR_ASSERT_NOW(a_stack_below_cursor, 1'b1, stack_count <= write_cursor)
  // A stack refill is never overtaken by another pop.
  `PSR_ASSERT_NOW(a_no_pop_during_refill, second_pend, !pop)
  // The drain never reads past the stored path.
  `PSR_ASSERT_NOW(a_drain_in_range, 1'b1, rd_idx <= drain_len)
  // A buffer read always lands in the read register.
  `PSR_ASSERT_NEXT(a_issue_fills_s1, issue, s1_valid)

endmodule

>>> tb/path_parent_segment_resolver_tb.sv
module path_parent_segment_resolver_tb;

  localparam int UNIT_TARGET    = 380;   // stop the random part after this many requests
  localparam int SETTLE_CYCLES  = 8;     // quiet cycles before a mode write
  localparam int DRAIN_CYCLES   = 20;    // quiet cycles after the last result
  localparam int LONG_HOLD      = 400;   // receiver hold-off for the back-pressure test
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake before giving up
  localparam int HOLD_PATH      = 12;    // random path that starts the long hold-off
  localparam int PAUSE_PATH     = 6;     // random path that waits for a full drain first

  localparam logic [psr_pkg::UNIT_W-1:0] CH_A = 16'h0061;
  localparam logic [psr_pkg::UNIT_W-1:0] CH_B = 16'h0062;
  localparam logic [psr_pkg::UNIT_W-1:0] CH_Q = 16'h0071;
  localparam logic [psr_pkg::UNIT_W-1:0] CH_Z = 16'h007A;

  // Predicts the normalized path from the accepted code units and checks
  // the emitted units against it in order.
  class path_board;
    logic [psr_pkg::UNIT_W-1:0] unit_mem [psr_pkg::MAX_LEN];
    logic [psr_pkg::ADDR_W-1:0] sep_pos [psr_pkg::MAX_LEN];
    int                         sep_depth;
    int                         cursor;
    int                         dot_run;
    bit                         non_dot;
    bit                         ovf_seen;
    bit                         unf_seen;
    bit                         parents_on;
    int                         errors;
    psr_pkg::result_t           normalized_units[$];

    function new();
      parents_on = 1'b1;
      errors     = 0;
      clear_path();
    endfunction

    function void clear_path();
      sep_depth = 0;
      cursor    = 0;
      dot_run   = 0;
      non_dot   = 1'b0;
      ovf_seen  = 1'b0;
      unf_seen  = 1'b0;
    endfunction

    // Append one unit, or drop it and flag overflow when the buffer is full.
    function void store_unit(logic [psr_pkg::UNIT_W-1:0] u);
      if (cursor < psr_pkg::MAX_LEN) begin
        unit_mem[cursor] = u;
        cursor++;
      end else begin
        ovf_seen = 1'b1;
      end
    endfunction

    function void take_unit(psr_pkg::item_t it);
      int               seg_start;
      bit               is_parent;
      psr_pkg::result_t res;
      if (it.code_unit == psr_pkg::UNIT_BACKSLASH || it.code_unit == psr_pkg::UNIT_SLASH) begin
        seg_start = (sep_depth > 0) ? int'(sep_pos[sep_depth-1]) + 1 : 0;
        is_parent = parents_on && dot_run == 2 && !non_dot && cursor == seg_start + 2;
        dot_run   = 0;
        non_dot   = 1'b0;
        if (is_parent) begin
          // Rewind over ".." and the segment before it; never eat the root slash.
          if (sep_depth == 0) begin
            cursor   = 0;
            unf_seen = 1'b1;
          end else if (sep_depth == 1) begin
            if (sep_pos[0] == '0) begin
              cursor   = 1;
              unf_seen = 1'b1;
            end else begin
              cursor    = 0;
              sep_depth = 0;
            end
          end else begin
            cursor = int'(sep_pos[sep_depth-2]) + 1;
            sep_depth--;
          end
        end else begin
          if (cursor < psr_pkg::MAX_LEN) begin
            sep_pos[sep_depth] = psr_pkg::ADDR_W'(cursor);
            sep_depth++;
          end
          store_unit(psr_pkg::UNIT_SLASH);
        end
      end else begin
        if (it.code_unit == psr_pkg::UNIT_DOT) begin
          if (dot_run < 3) dot_run++;
        end else begin
          non_dot = 1'b1;
        end
        store_unit(it.code_unit);
      end

      if (!it.last_unit) return;

      res.overflow_flag  = ovf_seen;
      res.underflow_flag = unf_seen;
      if (cursor == 0) begin
        res.out_unit   = '0;
        res.out_last   = 1'b1;
        res.path_empty = 1'b1;
        normalized_units.push_back(res);
      end else begin
        res.path_empty = 1'b0;
        for (int k = 0; k < cursor; k++) begin
          res.out_unit = unit_mem[k];
          res.out_last = (k == cursor - 1);
          normalized_units.push_back(res);
        end
      end
      clear_path();
    endfunction

    function void match_result(psr_pkg::result_t got);
      psr_pkg::result_t want;
      if (normalized_units.size() == 0) begin
        errors++;
        $error("unexpected result: out_unit %h out_last %b", got.out_unit, got.out_last);
        return;
      end
      want = normalized_units.pop_front();
      if (got.out_unit !== want.out_unit) begin
        errors++;
        $error("out_unit: expected %h, got %h", want.out_unit, got.out_unit);
      end
      if (got.out_last !== want.out_last) begin
        errors++;
        $error("out_last: expected %b, got %b", want.out_last, got.out_last);
      end
      if (got.path_empty !== want.path_empty) begin
        errors++;
        $error("path_empty: expected %b, got %b", want.path_empty, got.path_empty);
      end
      if (got.overflow_flag !== want.overflow_flag) begin
        errors++;
        $error("overflow_flag: expected %b, got %b", want.overflow_flag, got.overflow_flag);
      end
      if (got.underflow_flag !== want.underflow_flag) begin
        errors++;
        $error("underflow_flag: expected %b, got %b", want.underflow_flag,
               got.underflow_flag);
      end
    endfunction
  endclass

  logic             clk;
  logic             rst;
  logic             cfg_write;
  logic             cfg_data;
  logic             item_valid;
  logic             item_stall;
  psr_pkg::item_t   item;
  logic             result_valid;
  logic             result_stall;
  psr_pkg::result_t result;

  path_board                  board;
  logic [psr_pkg::UNIT_W-1:0] unit_seq[$];
  int                         units_sent;
  int                         quiet_cycles;
  bit                         tx_calm;
  bit                         rx_calm;
  bit                         hold_off_req;

  path_parent_segment_resolver u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  function automatic logic [psr_pkg::UNIT_W-1:0] pick_sep();
    return ($urandom_range(0, 1) == 0) ? psr_pkg::UNIT_SLASH : psr_pkg::UNIT_BACKSLASH;
  endfunction

  // Segment name content: mostly letters, sometimes any 16-bit unit.
  function automatic logic [psr_pkg::UNIT_W-1:0] name_unit();
    if ($urandom_range(0, 3) == 0) return psr_pkg::UNIT_W'($urandom_range(0, 65535));
    return CH_A + psr_pkg::UNIT_W'($urandom_range(0, 25));
  endfunction

  // Sample both handshakes at the edge; the board sees requests before
  // results so a same-edge result still pops an older path.
  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) board.take_unit(item);
      if (result_valid && !result_stall) board.match_result(result);
    end
  end

  // Watchdog: count cycles with no accepted request and no accepted result.
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (result_valid && !result_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Receiver: random stalls with calm stretches; one long hold-off on request.
  initial begin
    int left;
    left = 0;
    rx_calm = 1'b0;
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (left > 0) begin
        left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        left = LONG_HOLD;
      end else begin
        if ($urandom_range(0, 49) == 0) rx_calm = !rx_calm;
        if (!rx_calm && $urandom_range(0, 2) == 0) left = gap_len();
      end
      result_stall <= (left > 0);
    end
  end

  // Offer one request and hold it until the block takes it. Valid stays high
  // afterwards so back-to-back requests need no second assignment.
  task automatic send_unit(input logic [psr_pkg::UNIT_W-1:0] cu, input logic lu);
    int n;
    n = tx_calm ? 0 : gap_len();
    if (n > 0) begin
      item_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    item_valid <= 1'b1;
    item       <= '{code_unit: cu, last_unit: lu};
    do @(posedge clk); while (item_stall);
    units_sent++;
  endtask

  // Drop valid and wait until every predicted unit has come out, then let
  // the block sit quiet for a while.
  task automatic drain_results(input int extra);
    item_valid <= 1'b0;
    @(posedge clk);
    while (board.normalized_units.size() > 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  // Write the mode only while the block is idle.
  task automatic set_parents(input bit on);
    drain_results(SETTLE_CYCLES);
    cfg_write <= 1'b1;
    cfg_data  <= on;
    @(posedge clk);
    cfg_write <= 1'b0;
    board.parents_on = on;
  endtask

  // Send unit_seq as one path; flip the mode before unit split_at if asked.
  task automatic send_path(input int split_at, input bit split_mode);
    for (int i = 0; i < unit_seq.size(); i++) begin
      if (i == split_at) set_parents(split_mode);
      send_unit(unit_seq[i], i == unit_seq.size() - 1);
    end
  endtask

  initial begin
    int len;
    int nseg;
    int pick;
    int path_no;
    board        = new();
    units_sent   = 0;
    path_no      = 0;
    tx_calm      = 1'b0;
    hold_off_req = 1'b0;
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_data     <= 1'b0;
    item_valid   <= 1'b0;
    item         <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed paths, run with the reset mode (resolve on).
    // Parent at the start: everything goes, empty path with underflow.
    unit_seq = '{psr_pkg::UNIT_DOT, psr_pkg::UNIT_DOT, psr_pkg::UNIT_SLASH};
    send_path(-1, 1'b0);
    // Root protected: the leading slash survives a "..".
    unit_seq = '{psr_pkg::UNIT_SLASH, psr_pkg::UNIT_DOT, psr_pkg::UNIT_DOT,
                 psr_pkg::UNIT_BACKSLASH};
    send_path(-1, 1'b0);
    // Plain rewind over backslashes, lowest code unit as the segment.
    unit_seq = '{16'h0000, psr_pkg::UNIT_SLASH, psr_pkg::UNIT_DOT, psr_pkg::UNIT_DOT,
                 psr_pkg::UNIT_BACKSLASH, CH_B};
    send_path(-1, 1'b0);
    // Dots inside a segment and a trailing ".." without separator are kept.
    unit_seq = '{16'hFFFF, psr_pkg::UNIT_DOT, psr_pkg::UNIT_DOT, psr_pkg::UNIT_BACKSLASH,
                 psr_pkg::UNIT_DOT, psr_pkg::UNIT_DOT};
    send_path(-1, 1'b0);
    // Turn resolving off in mid-path: the ".." must stay.
    unit_seq = '{CH_A, psr_pkg::UNIT_SLASH, psr_pkg::UNIT_DOT, psr_pkg::UNIT_DOT,
                 psr_pkg::UNIT_SLASH};
    send_path(2, 1'b0);
    set_parents(1'b1);

    // Full buffer: the second dot and everything after it are dropped,
    // so the ".." must not resolve.
    unit_seq.delete();
    repeat (62) unit_seq.push_back(CH_Q);
    unit_seq.push_back(psr_pkg::UNIT_SLASH);
    unit_seq.push_back(psr_pkg::UNIT_DOT);
    unit_seq.push_back(psr_pkg::UNIT_DOT);
    unit_seq.push_back(psr_pkg::UNIT_SLASH);
    unit_seq.push_back(CH_Z);
    send_path(-1, 1'b0);

    // Random paths: mostly well-formed segments, some noise.
    while (units_sent < UNIT_TARGET) begin
      path_no++;
      tx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) == 0) set_parents($urandom_range(0, 3) != 0);
      unit_seq.delete();
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 10);
        repeat (len) begin
          pick = $urandom_range(0, 3);
          if (pick == 0) unit_seq.push_back(psr_pkg::UNIT_W'($urandom_range(0, 65535)));
          else if (pick == 1) unit_seq.push_back(psr_pkg::UNIT_DOT);
          else if (pick == 2) unit_seq.push_back(pick_sep());
          else unit_seq.push_back(name_unit());
        end
      end else begin
        if ($urandom_range(0, 2) == 0) unit_seq.push_back(pick_sep());
        // Now and then a long leading name pushes the tail past the buffer end.
        if ($urandom_range(0, 24) == 0) begin
          len = $urandom_range(52, 66);
          repeat (len) unit_seq.push_back(name_unit());
          unit_seq.push_back(pick_sep());
        end
        nseg = $urandom_range(1, 6);
        for (int s = 0; s < nseg; s++) begin
          pick = $urandom_range(0, 9);
          if (pick < 3) begin
            unit_seq.push_back(psr_pkg::UNIT_DOT);
            unit_seq.push_back(psr_pkg::UNIT_DOT);
          end else if (pick == 3) begin
            unit_seq.push_back(psr_pkg::UNIT_DOT);
          end else if (pick == 4) begin
            repeat (3) unit_seq.push_back(psr_pkg::UNIT_DOT);
          end else if (pick == 5) begin
            unit_seq.push_back(psr_pkg::UNIT_DOT);
            unit_seq.push_back(psr_pkg::UNIT_DOT);
            unit_seq.push_back(name_unit());
          end else begin
            len = $urandom_range(1, 4);
            repeat (len) unit_seq.push_back(name_unit());
          end
          if (s < nseg - 1 || $urandom_range(0, 2) == 0) unit_seq.push_back(pick_sep());
        end
      end

      // Back-pressure: stall the receiver for a long stretch while the
      // sender keeps pushing requests back to back.
      if (path_no >= HOLD_PATH && path_no < HOLD_PATH + 4) tx_calm = 1'b1;
      if (path_no == HOLD_PATH) hold_off_req = 1'b1;
      // Hold the sender until the result side is completely empty.
      if (path_no == PAUSE_PATH) drain_results(0);

      if ($urandom_range(0, 29) == 0 && unit_seq.size() > 1)
        send_path($urandom_range(1, unit_seq.size() - 1), 1'($urandom_range(0, 1)));
      else
        send_path(-1, 1'b0);
    end

    drain_results(DRAIN_CYCLES);
    if (board.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/psr_pkg.sv
hw/rtl/psr_ram.sv
hw/rtl/path_parent_segment_resolver.sv
tb/path_parent_segment_resolver_tb.sv
